// File: rtl/dfd_pkg.sv
// ----------------------------------------------------------------------------
// dfd_pkg
// Types and constants shared by the detector frame byte deframer.
// ----------------------------------------------------------------------------
package dfd_pkg;

    // parse phases
    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_ITEMS   = 2'd1;
    localparam logic [1:0] PH_TRAILER = 2'd2;

    // header byte offsets
    localparam logic [29:0] POS_FLEN_HI  = 30'd1;
    localparam logic [29:0] POS_FLEN_MID = 30'd2;
    localparam logic [29:0] POS_FLEN_LO  = 30'd3;
    localparam logic [29:0] POS_HLEN_HI  = 30'd8;
    localparam logic [29:0] POS_HLEN_LO  = 30'd9;
    localparam logic [29:0] POS_CNT_B0   = 30'd12;
    localparam logic [29:0] POS_CNT_B1   = 30'd13;
    localparam logic [29:0] POS_CNT_B2   = 30'd14;
    localparam logic [29:0] POS_CNT_B3   = 30'd15;
    localparam logic [29:0] POS_ENDCALC  = 30'd16;
    localparam logic [29:0] POS_SKIPCALC = 30'd17;
    localparam logic [29:0] POS_EVT_B0   = 30'd22;
    localparam logic [29:0] POS_EVT_B1   = 30'd23;
    localparam logic [29:0] POS_EVT_B2   = 30'd24;
    localparam logic [29:0] POS_EVT_B3   = 30'd25;
    localparam logic [29:0] POS_BOARD    = 30'd26;
    localparam logic [29:0] POS_CARD     = 30'd27;

    localparam logic [21:0] MIN_HEADER  = 22'd28;
    localparam logic [6:0]  MAX_CHANNEL = 7'd68;
    localparam logic [1:0]  WORD_LAST_BYTE = 2'd3;

    typedef struct packed {
        logic [31:0] frame_number;
        logic [31:0] event_id;
        logic [7:0]  board_id;
        logic [7:0]  card_id;
        logic [1:0]  chip_index;
        logic [6:0]  channel_index;
        logic [8:0]  bucket_index;
        logic [11:0] sample_value;
        logic        accepted;
        logic        last_item;
    } dfd_result_t;

endpackage

// File: rtl/dfd_in_stage.sv
// ----------------------------------------------------------------------------
// dfd_in_stage
// Input byte register; releases one byte per cycle while down_ready is high.
// ----------------------------------------------------------------------------
module dfd_in_stage (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] data_byte,
    input  logic       down_ready,
    output logic       step_en,
    output logic [7:0] step_byte
);
    logic       hold_valid_reg;
    logic       hold_valid_next;
    logic [7:0] hold_byte_reg;
    logic       take;

    assign step_en    = hold_valid_reg && down_ready;
    assign byte_stall = hold_valid_reg && !down_ready;
    assign take       = byte_valid && !byte_stall;
    assign step_byte  = hold_byte_reg;

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        if (take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            hold_byte_reg <= data_byte;
        end
    end

endmodule

// File: rtl/dfd_parser.sv
// ----------------------------------------------------------------------------
// dfd_parser
// Frame state and item word decode; state advances once per step_en.
// ----------------------------------------------------------------------------
module dfd_parser #(
    parameter int TIME_BUCKETS = 512
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic [7:0]           step_byte,
    output logic                 res_valid,
    output dfd_pkg::dfd_result_t res
);
    import dfd_pkg::*;

    localparam logic [9:0] BUCKET_LIMIT = 10'(TIME_BUCKETS);

    logic [1:0]  phase_reg,       phase_next;
    logic [29:0] pos_reg,         pos_next;
    logic [29:0] frame_len_reg,   frame_len_next;
    logic [21:0] hdr_len_reg,     hdr_len_next;
    logic [31:0] items_total_reg, items_total_next;
    logic [31:0] items_left_reg,  items_left_next;
    logic [31:0] event_reg,       event_next;
    logic [7:0]  board_reg,       board_next;
    logic [7:0]  card_reg,        card_next;
    logic [23:0] word_reg,        word_next;
    logic [31:0] frame_cnt_reg,   frame_cnt_next;
    logic [34:0] items_end_reg,   items_end_next;
    logic        skip_reg,        skip_next;

    logic [29:0] pos_inc;
    logic [21:0] hdr_end;
    logic [31:0] word;
    logic        last;

    assign pos_inc = pos_reg + 30'd1;
    assign hdr_end = (hdr_len_reg < MIN_HEADER) ? MIN_HEADER : hdr_len_reg;
    assign word    = {word_reg, step_byte};
    assign last    = (items_left_reg == 32'd1);

    always_comb
    begin
        res.frame_number  = frame_cnt_reg;
        res.event_id      = event_reg;
        res.board_id      = board_reg;
        res.card_id       = card_reg;
        res.chip_index    = word[31:30];
        res.channel_index = word[29:23];
        res.bucket_index  = word[22:14];
        res.sample_value  = word[11:0];
        res.accepted      = (word[29:23] < MAX_CHANNEL)
                            && ({1'b0, word[22:14]} < BUCKET_LIMIT);
        res.last_item     = last;
        res_valid = (phase_reg == PH_ITEMS) && (pos_reg[1:0] == WORD_LAST_BYTE);
    end

    always_comb
    begin
        phase_next       = phase_reg;
        pos_next         = pos_reg;
        frame_len_next   = frame_len_reg;
        hdr_len_next     = hdr_len_reg;
        items_total_next = items_total_reg;
        items_left_next  = items_left_reg;
        event_next       = event_reg;
        board_next       = board_reg;
        card_next        = card_reg;
        word_next        = word_reg;
        frame_cnt_next   = frame_cnt_reg;
        items_end_next   = items_end_reg;
        skip_next        = skip_reg;

        unique case (phase_reg)
            PH_ITEMS:
            begin
                if (pos_reg[1:0] != WORD_LAST_BYTE)
                begin
                    word_next = {word_reg[15:0], step_byte};
                    pos_next  = pos_inc;
                end
                else
                begin
                    items_left_next = items_left_reg - 32'd1;
                    word_next       = '0;
                    pos_next        = '0;
                    if (last)
                    begin
                        if (skip_reg)
                        begin
                            frame_cnt_next = frame_cnt_reg + 32'd1;
                            phase_next     = PH_HEADER;
                        end
                        else
                        begin
                            phase_next = PH_TRAILER;
                            pos_next   = items_end_reg[29:0];
                        end
                    end
                end
            end
            PH_TRAILER:
            begin
                pos_next = pos_inc;
                if (pos_inc >= frame_len_reg)
                begin
                    frame_cnt_next = frame_cnt_reg + 32'd1;
                    phase_next     = PH_HEADER;
                    pos_next       = '0;
                end
            end
            default:
            begin
                // header; the unused phase code lands here too
                unique case (pos_reg)
                    POS_FLEN_HI:  frame_len_next = {step_byte, 22'd0};
                    POS_FLEN_MID: frame_len_next[21:14] = step_byte;
                    POS_FLEN_LO:  frame_len_next[13:6] = step_byte;
                    POS_HLEN_HI:  hdr_len_next = {step_byte, 14'd0};
                    POS_HLEN_LO:  hdr_len_next[13:6] = step_byte;
                    POS_CNT_B0:   items_total_next = {24'd0, step_byte};
                    POS_CNT_B1, POS_CNT_B2, POS_CNT_B3:
                        items_total_next = {items_total_reg[23:0], step_byte};
                    // all sizes are final here; end of items settles early
                    POS_ENDCALC:
                        items_end_next = {13'd0, hdr_end}
                                         + {1'b0, items_total_reg, 2'b00};
                    POS_SKIPCALC:
                        skip_next = (items_end_reg >= {5'd0, frame_len_reg});
                    POS_EVT_B0:   event_next = {24'd0, step_byte};
                    POS_EVT_B1, POS_EVT_B2, POS_EVT_B3:
                        event_next = {event_reg[23:0], step_byte};
                    POS_BOARD:    board_next = step_byte;
                    POS_CARD:     card_next = step_byte;
                    default:      ;
                endcase
                pos_next = pos_inc;
                if (pos_inc >= {8'd0, hdr_end})
                begin
                    items_left_next = items_total_reg;
                    word_next       = '0;
                    if (items_total_reg == 32'd0)
                    begin
                        if (skip_reg)
                        begin
                            frame_cnt_next = frame_cnt_reg + 32'd1;
                            phase_next     = PH_HEADER;
                            pos_next       = '0;
                        end
                        else
                        begin
                            phase_next = PH_TRAILER;
                            pos_next   = items_end_reg[29:0];
                        end
                    end
                    else
                    begin
                        phase_next = PH_ITEMS;
                        pos_next   = '0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_HEADER;
            pos_reg         <= '0;
            frame_len_reg   <= '0;
            hdr_len_reg     <= '0;
            items_total_reg <= '0;
            items_left_reg  <= '0;
            event_reg       <= '0;
            board_reg       <= '0;
            card_reg        <= '0;
            word_reg        <= '0;
            frame_cnt_reg   <= '0;
            items_end_reg   <= '0;
            skip_reg        <= 1'b0;
        end
        else if (step_en)
        begin
            phase_reg       <= phase_next;
            pos_reg         <= pos_next;
            frame_len_reg   <= frame_len_next;
            hdr_len_reg     <= hdr_len_next;
            items_total_reg <= items_total_next;
            items_left_reg  <= items_left_next;
            event_reg       <= event_next;
            board_reg       <= board_next;
            card_reg        <= card_next;
            word_reg        <= word_next;
            frame_cnt_reg   <= frame_cnt_next;
            items_end_reg   <= items_end_next;
            skip_reg        <= skip_next;
        end
    end

`ifndef SYNTHESIS
    a_last_leaves_items: assert property (@(posedge clk) disable iff (!rst_n)
        step_en && res_valid && res.last_item |=> phase_reg != PH_ITEMS)
        else $error("item phase continues after last item");

    a_items_pending: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ITEMS |-> items_left_reg != 32'd0)
        else $error("item phase with no items left");

    a_word_index: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_ITEMS |-> pos_reg[29:2] == 28'd0)
        else $error("word byte index out of range");

    a_trailer_bound: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_TRAILER |-> pos_reg < frame_len_reg)
        else $error("trailer position past frame end");

    a_frame_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(frame_cnt_reg) |-> frame_cnt_reg == $past(frame_cnt_reg) + 32'd1
                                    && phase_reg == PH_HEADER)
        else $error("frame count jumped");
`endif

endmodule

// File: rtl/dfd_out_stage.sv
// ----------------------------------------------------------------------------
// dfd_out_stage
// Result register; holds a finished item until the consumer takes it.
// ----------------------------------------------------------------------------
module dfd_out_stage (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step_en,
    input  logic                 res_valid,
    input  dfd_pkg::dfd_result_t res,
    input  logic                 result_stall,
    output logic                 result_valid,
    output dfd_pkg::dfd_result_t result,
    output logic                 down_ready
);
    import dfd_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    dfd_result_t result_reg;

    assign down_ready   = !valid_reg || !result_stall;
    assign result_valid = valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (step_en)
        begin
            valid_next = res_valid;
        end
        else if (!result_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && res_valid)
        begin
            result_reg <= res;
        end
    end

endmodule

// File: rtl/detector_frame_byte_deframer_unit.sv
// ----------------------------------------------------------------------------
// detector_frame_byte_deframer_unit
// Path: byte accept to result valid goes through the input reg, then result reg.
// Throughput: one byte per cycle while result_stall is low; the fourth byte
// of each item word yields one result, all other bytes yield none.
// Reset: async active low; clears all frame state, starts in header phase.
// ----------------------------------------------------------------------------
module detector_frame_byte_deframer_unit #(
    parameter int TIME_BUCKETS = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [31:0] frame_number,
    output logic [31:0] event_id,
    output logic [7:0]  board_id,
    output logic [7:0]  card_id,
    output logic [1:0]  chip_index,
    output logic [6:0]  channel_index,
    output logic [8:0]  bucket_index,
    output logic [11:0] sample_value,
    output logic        accepted,
    output logic        last_item
);
    import dfd_pkg::*;

    logic        down_ready;
    logic        step_en;
    logic [7:0]  step_byte;
    logic        res_valid;
    dfd_result_t res;
    dfd_result_t result;

    dfd_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .data_byte  (data_byte),
        .down_ready (down_ready),
        .step_en    (step_en),
        .step_byte  (step_byte)
    );

    dfd_parser #(
        .TIME_BUCKETS (TIME_BUCKETS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (step_en),
        .step_byte (step_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    dfd_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .res_valid    (res_valid),
        .res          (res),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result),
        .down_ready   (down_ready)
    );

    assign frame_number  = result.frame_number;
    assign event_id      = result.event_id;
    assign board_id      = result.board_id;
    assign card_id       = result.card_id;
    assign chip_index    = result.chip_index;
    assign channel_index = result.channel_index;
    assign bucket_index  = result.bucket_index;
    assign sample_value  = result.sample_value;
    assign accepted      = result.accepted;
    assign last_item     = result.last_item;

endmodule
